// File: src/ovl_pkg.sv
// Package for the ordered value list: request codes, status codes, double compare.
// No dependencies.
package ovl_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_MEMBER  = 3'd1,
    REQ_POS     = 3'd2,
    REQ_REMOVE  = 3'd3,
    REQ_REVERSE = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic [63:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;

  // IEEE double equality on bit patterns
  function automatic logic dbl_equal(input logic [63:0] a, input logic [63:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a & ABS_MASK) > INF_BITS;
    b_nan = (b & ABS_MASK) > INF_BITS;
    if (a_nan || b_nan) return 1'b0;
    if (((a & ABS_MASK) == 64'd0) && ((b & ABS_MASK) == 64'd0)) return 1'b1;
    return a == b;
  endfunction

endpackage

// File: src/ovl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ovl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/ordered_value_list_core.sv
// Ordered value list: bounded list of doubles, one RAM plus a sequencer.
// Insert, clear, unused codes, empty-list searches and short reverses go straight to DONE;
// a search walks the elements from the front, a remove hit shifts later ones down, a reverse swaps pairs.
// One request at a time; the next word is accepted the cycle after the result is registered,
// and a result waits in DONE only while the previous word is still stalled.
// Reset: synchronous, empties the list; RAM contents are not cleared. Depends on ovl_pkg, ovl_ram.
module ordered_value_list_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [4:0]  position,
  output logic [4:0]  entry_count,
  output logic [1:0]  status
);
  import ovl_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_SHIFT, S_REV_A, S_REV_B, S_REV_C, S_DONE
  } state_t;

  state_t state;
  logic [2:0]    req;
  logic [63:0]   val;
  logic [CW-1:0] used;
  // logical head slot: list element k is RAM slot (head + k) mod DEPTH
  logic [AW-1:0] head;
  logic [CW-1:0] idx;   // element index of current step
  logic [CW-1:0] hi;
  logic [63:0]   tmp;
  logic          rd_pend;
  // result held here until the output word is free
  logic          r_found;
  logic [4:0]    r_pos;
  logic [1:0]    r_status;
  logic          rev_more;
  logic          emit;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  ovl_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // element index to RAM slot
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign in_stall = (state != S_IDLE);

  // another reverse pair remains, or the result can be registered
  assign rev_more = (req == REQ_REVERSE) && rd_pend && (idx + CW'(2) < hi);
  assign emit     = (state == S_DONE) && !rev_more && (!out_valid || !out_stall);

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = val;
    raddr = slot(head, idx);
    case (state)
      S_IDLE: begin
        raddr = slot(head, '0);
        if (in_valid && req_type == REQ_INSERT && used < CW'(DEPTH)) begin
          we    = 1'b1;
          waddr = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
          wdata = value;
        end
      end
      S_SHIFT: begin
        // copy element idx+1 (rdata) into element idx
        raddr = slot(head, rd_pend ? idx + CW'(2) : idx + CW'(1));
        if (rd_pend) begin
          we    = 1'b1;
          waddr = slot(head, idx);
          wdata = rdata;
        end
      end
      S_REV_A: raddr = slot(head, idx);
      S_REV_B: raddr = slot(head, hi);
      S_REV_C: begin
        we    = 1'b1;
        waddr = slot(head, idx);
        wdata = rdata;
      end
      S_DONE: begin
        we    = (req == REQ_REVERSE) && rd_pend;
        waddr = slot(head, hi);
        wdata = tmp;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      head      <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req      <= req_type;
            val      <= value;
            idx      <= '0;
            r_found  <= 1'b0;
            r_pos    <= '0;
            r_status <= ST_OK;
            rd_pend  <= 1'b0;
            state    <= S_DONE;
            case (req_type)
              REQ_INSERT: begin
                if (used < CW'(DEPTH)) begin
                  head <= (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
                  used <= used + 1'b1;
                end else r_status <= ST_FULL;
              end
              REQ_MEMBER, REQ_POS, REQ_REMOVE: begin
                if (used == '0) r_status <= ST_EMPTY;
                else begin
                  state <= S_SEARCH;
                  idx   <= CW'(1);
                end
              end
              REQ_REVERSE: begin
                if (used > CW'(1)) begin
                  hi    <= used - 1'b1;
                  state <= S_REV_A;
                end
              end
              REQ_CLEAR: used <= '0;
              default: ;
            endcase
          end
        end
        // rdata holds element idx-1
        S_SEARCH: begin
          if (dbl_equal(rdata, val)) begin
            r_found <= 1'b1;
            r_pos   <= 5'(idx);
            if (req == REQ_REMOVE) begin
              idx     <= idx - 1'b1;
              rd_pend <= 1'b0;
              state   <= S_SHIFT;
            end else state <= S_DONE;
          end else if (idx == used) begin
            r_status <= ST_NOTFOUND;
            state    <= S_DONE;
          end else idx <= idx + 1'b1;
        end
        // first cycle primes a read of idx+1 (raddr idx+2 is next one)
        S_SHIFT: begin
          if (!rd_pend) begin
            if (idx + CW'(1) >= used) begin
              used  <= used - 1'b1;
              state <= S_DONE;
            end else rd_pend <= 1'b1;
          end else if (idx + CW'(2) >= used) begin
            used    <= used - 1'b1;
            rd_pend <= 1'b0;
            state   <= S_DONE;
          end else idx <= idx + 1'b1;
        end
        S_REV_A: state <= S_REV_B;
        S_REV_B: begin
          tmp   <= rdata;  // element idx
          state <= S_REV_C;
        end
        S_REV_C: begin
          // element idx <= element hi done; write tmp to hi next
          rd_pend <= 1'b1;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (rev_more) begin
            rd_pend <= 1'b0;
            idx     <= idx + 1'b1;
            hi      <= hi - 1'b1;
            state   <= S_REV_A;
          end else if (emit) begin
            rd_pend     <= 1'b0;
            found       <= r_found;
            position    <= r_pos;
            status      <= r_status;
            entry_count <= 5'(used);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: bench/tb.sv
// Self-checking bench for ordered_value_list_core: random and directed list requests,
// predicted in place and compared word by word. Depends on ovl_pkg and the core RTL.
module tb;
  import ovl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [2:0]  req;
    logic [63:0] val;
  } list_req_t;

  typedef struct packed {
    logic       found;
    logic [4:0] position;
    logic [4:0] entry_count;
    logic [1:0] status;
  } list_rsp_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  req_type;
  logic [63:0] value;
  logic        out_valid;
  logic        out_stall;
  logic        found;
  logic [4:0]  position;
  logic [4:0]  entry_count;
  logic [1:0]  status;

  ordered_value_list_core #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .value(value), .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .position(position), .entry_count(entry_count), .status(status)
  );

  list_req_t   pending_reqs[$];
  list_rsp_t   expected_rsps[$];
  logic [63:0] model_list[DEPTH];
  int          model_count;
  int          errors;
  int          words_in;
  int          words_out;
  int          send_gap;
  int          stall_left;
  bit          drain_hold;
  int          op_hits[8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb failed");
    $finish;
  end

  // IEEE equality, written independently of the package
  function automatic bit model_match(logic [63:0] a, logic [63:0] b);
    bit a_nan;
    bit b_nan;
    a_nan = a[62:52] == 11'h7FF && a[51:0] != 0;
    b_nan = b[62:52] == 11'h7FF && b[51:0] != 0;
    if (a_nan || b_nan) return 0;
    if (a[62:0] == 0 && b[62:0] == 0) return 1;
    return a == b;
  endfunction

  // apply one request to the shadow list and return the expected word
  function automatic list_rsp_t list_predict(list_req_t r);
    list_rsp_t  o;
    int         idx;
    logic [63:0] t;
    o = '0;
    idx = -1;
    case (r.req)
      REQ_INSERT: begin
        if (model_count >= DEPTH) o.status = ST_FULL;
        else begin
          for (int i = model_count; i > 0; i--) model_list[i] = model_list[i-1];
          model_list[0] = r.val;
          model_count++;
        end
      end
      REQ_MEMBER, REQ_POS, REQ_REMOVE: begin
        if (model_count == 0) o.status = ST_EMPTY;
        else begin
          for (int i = 0; i < model_count; i++)
            if (idx < 0 && model_match(model_list[i], r.val)) idx = i;
          if (idx < 0) o.status = ST_NOTFOUND;
          else begin
            o.found = 1;
            o.position = 5'(idx + 1);
            if (r.req == REQ_REMOVE) begin
              for (int i = idx; i + 1 < model_count; i++) model_list[i] = model_list[i+1];
              model_count--;
            end
          end
        end
      end
      REQ_REVERSE: begin
        for (int i = 0; i < model_count / 2; i++) begin
          t = model_list[i];
          model_list[i] = model_list[model_count-1-i];
          model_list[model_count-1-i] = t;
        end
      end
      REQ_CLEAR: model_count = 0;
      default: ;
    endcase
    o.entry_count = 5'(model_count);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at word %0d: %s got %0h want %0h", words_out, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // a random value, often a small one or a special pattern
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'h0;
      1: v = 64'h8000_0000_0000_0000;
      2: v = {1'b0, 11'h7FF, 20'($urandom), 32'($urandom)} | 64'h1;
      3: v = 64'(($urandom_range(0, 5)));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      req_type <= '0;
      value    <= '0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !(drain_hold && (expected_rsps.size() > 0
                                               || (in_valid && !in_stall)))) begin
        list_req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        req_type <= r.req;
        value    <= r.val;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict at acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      list_req_t r;
      r.req = req_type;
      r.val = value;
      expected_rsps.push_back(list_predict(r));
      op_hits[req_type]++;
      words_in++;
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        list_rsp_t e;
        words_out++;
        if (expected_rsps.size() == 0) begin
          $display("unexpected word %0d", words_out);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (found !== e.found) report_mismatch("found", found, e.found);
          if (position !== e.position) report_mismatch("position", position, e.position);
          if (entry_count !== e.entry_count)
            report_mismatch("entry_count", entry_count, e.entry_count);
          if (status !== e.status) report_mismatch("status", status, e.status);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
        out_stall  <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  task automatic queue_req(logic [2:0] q, logic [63:0] v);
    list_req_t r;
    r.req = q;
    r.val = v;
    pending_reqs.push_back(r);
  endtask

  initial begin
    int wait_cycles;
    errors = 0; words_in = 0; words_out = 0; drain_hold = 0;
    model_count = 0;
    foreach (op_hits[i]) op_hits[i] = 0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, zero signs, NaN, full list, reverse, clear, unused codes
    queue_req(REQ_MEMBER, 64'h0);
    queue_req(REQ_REMOVE, 64'h0);
    queue_req(REQ_REVERSE, 64'h0);
    queue_req(REQ_INSERT, 64'h8000_0000_0000_0000);
    queue_req(REQ_POS, 64'h0);
    queue_req(REQ_INSERT, 64'h7FF8_0000_0000_0000);
    queue_req(REQ_MEMBER, 64'h7FF8_0000_0000_0000);
    queue_req(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(REQ_INSERT, 64'h7FF0_0000_0000_0000);
    queue_req(REQ_REMOVE, 64'h1234);
    queue_req(REQ_REVERSE, 64'h0);
    queue_req(3'd6, 64'h0);
    queue_req(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 13; i++) queue_req(REQ_INSERT, 64'(i + 1));
    queue_req(REQ_INSERT, 64'h55);
    queue_req(REQ_POS, 64'h1);
    queue_req(REQ_REMOVE, 64'h8000_0000_0000_0000);
    queue_req(REQ_CLEAR, 64'h0);

    while (pending_reqs.size() > 0) @(posedge clk);
    // until the early random requests are sent, the sender waits for every outstanding word
    drain_hold = 1;
    queue_req(REQ_MEMBER, 64'h0);

    // random: insert-heavy, with searches, removes, reverses, rare clears and unused codes
    for (int i = 0; i < 1000; i++) begin
      int k;
      k = $urandom_range(0, 99);
      if (k < 35) queue_req(REQ_INSERT, pick_value());
      else if (k < 55) queue_req(REQ_MEMBER, pick_value());
      else if (k < 70) queue_req(REQ_POS, pick_value());
      else if (k < 88) queue_req(REQ_REMOVE, pick_value());
      else if (k < 94) queue_req(REQ_REVERSE, {$urandom, $urandom});
      else if (k < 97) queue_req(REQ_CLEAR, {$urandom, $urandom});
      else queue_req(3'($urandom_range(6, 7)), {$urandom, $urandom});
      if (i == 10) begin
        while (pending_reqs.size() > 0) @(posedge clk);
        drain_hold = 0;
      end
    end

    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
    wait_cycles = 0;
    while (expected_rsps.size() > 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);

    $display("covered %0d requests (insert %0d, member %0d, pos %0d, remove %0d)",
             words_in, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
    $display("reverse %0d, clear %0d, unused codes %0d, %0d words checked",
             op_hits[4], op_hits[5], op_hits[6] + op_hits[7], words_out);
    if (expected_rsps.size() > 0) begin
      $display("%0d words never arrived", expected_rsps.size());
      errors++;
    end
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
